FILE: rtl/core/rahe_pkg.sv
// Package for the ROM address homophonic encoder.
// Shared payload and command types, operation codes and default sizes.
// No dependencies.
`default_nettype none

package rahe_pkg;

  localparam int RomIdxW    = 3;
  localparam int RomCountW  = 2;
  localparam int DefWindow  = 65536;
  localparam int DefNumRoms = 3;
  localparam int QDepth     = 2;

  localparam logic OpLoad   = 1'b0;
  localparam logic OpEncode = 1'b1;

  localparam logic [RomCountW-1:0] RomCountReset = 2'd1;

  typedef struct packed {
    logic        op;
    logic [1:0]  rom_select;
    logic [7:0]  data_byte;
    logic [31:0] random_value;
    logic        last_rom_byte;
  } in_t;

  typedef struct packed {
    logic [15:0] rom_address;
    logic [1:0]  rom_used;
  } out_t;

  // Command handed from the front to the back.
  typedef struct packed {
    logic               op;
    logic [RomIdxW-1:0] rom;
    logic [7:0]         data_byte;
    logic [31:0]        random_value;
    logic               last_rom_byte;
  } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/core/rahe_front.sv
// Front end: input transfer, rotation over ROMs, rom_count register and command queue.
// Depends on rahe_pkg.
`default_nettype none

module rahe_front import rahe_pkg::*; #(
  parameter int NUM_ROMS = DefNumRoms
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  in_t                  in_data_i,
  input  wire                  cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire [RomCountW-1:0]  cfg_data_i,
  output logic                 cmd_valid_o,
  output cmd_t                 cmd_o,
  input  wire                  cmd_pop_i
);

  localparam int QPW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCW = $clog2(QDepth + 1);

  logic [RomCountW-1:0] rom_count_q;
  logic [1:0]           pos_q, pos_d;
  logic [RomCountW-1:0] eff_cnt;
  logic [1:0]           rom_pick;
  cmd_t                 q_mem [QDepth];
  logic [QPW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [QCW-1:0]       cnt_q;
  logic                 accept, push, pop;
  cmd_t                 cmd_new;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (cnt_q != QCW'(QDepth));
  assign accept      = in_valid_i & in_ready_o;
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = q_mem[rd_ptr_q];
  assign pop         = cmd_pop_i & cmd_valid_o;

  always_comb begin
    if (rom_count_q == '0) begin
      eff_cnt = RomCountW'(1);
    end else if (32'(rom_count_q) > NUM_ROMS) begin
      eff_cnt = RomCountW'(NUM_ROMS);
    end else begin
      eff_cnt = rom_count_q;
    end
    if (pos_q >= eff_cnt) begin
      rom_pick = (eff_cnt == RomCountW'(1)) ? 2'd0 : pos_q - eff_cnt;
    end else begin
      rom_pick = pos_q;
    end
  end

  always_comb begin
    cmd_new               = '0;
    cmd_new.op            = in_data_i.op;
    cmd_new.data_byte     = in_data_i.data_byte;
    cmd_new.random_value  = in_data_i.random_value;
    cmd_new.last_rom_byte = in_data_i.last_rom_byte;
    pos_d                 = pos_q;
    push                  = 1'b0;
    if (accept) begin
      if (in_data_i.op == OpLoad) begin
        pos_d       = 2'd0;
        cmd_new.rom = RomIdxW'(in_data_i.rom_select);
        // loads to a ROM that does not exist are dropped here
        push        = (32'(in_data_i.rom_select) < NUM_ROMS);
      end else begin
        cmd_new.rom = RomIdxW'(rom_pick);
        pos_d       = ((rom_pick + 2'd1) == eff_cnt) ? 2'd0 : rom_pick + 2'd1;
        push        = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_count_q <= RomCountReset;
      pos_q       <= 2'd0;
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      cnt_q       <= '0;
    end else begin
      if (cfg_valid_i) begin
        rom_count_q <= cfg_data_i;
      end
      pos_q <= pos_d;
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QPW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QPW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/rahe_urem.sv
// Bit-serial unsigned remainder of a 32-bit dividend, one bit per cycle.
// Depends on rahe_pkg.
`default_nettype none

module rahe_urem import rahe_pkg::*; #(
  parameter int VW = 17
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           start_i,
  input  wire [31:0]    dividend_i,
  input  wire [VW-1:0]  divisor_i,
  output logic          done_o,
  output logic [VW-1:0] rem_o
);

  logic          busy_q, done_q;
  logic [4:0]    step_q;
  logic [31:0]   num_q;
  logic [VW-1:0] div_q, rem_q;
  logic [VW:0]   trial;

  assign trial  = {rem_q, num_q[31]};
  assign done_o = done_q;
  assign rem_o  = rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 5'd1;
        if (step_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[30:0], 1'b0};
      // remainder stays below the divisor, so the trial fits one extra bit
      if (trial >= {1'b0, div_q}) begin
        rem_q <= VW'(trial - {1'b0, div_q});
      end else begin
        rem_q <= VW'(trial);
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/rahe_back.sv
// Back end: ROM storage, index build sequencer, encode lookup and result register.
// Depends on rahe_pkg and rahe_urem.
`default_nettype none

module rahe_back import rahe_pkg::*; #(
  parameter int ROM_WINDOW = DefWindow,
  parameter int NUM_ROMS   = DefNumRoms
) (
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   cmd_valid_i,
  input  cmd_t  cmd_i,
  output logic  cmd_pop_o,
  output logic  out_valid_o,
  input  wire   out_ready_i,
  output out_t  out_data_o
);

  localparam int FPW   = $clog2(ROM_WINDOW + 1);
  localparam int AW    = $clog2(ROM_WINDOW);
  localparam int MemD  = NUM_ROMS * ROM_WINDOW;
  localparam int MemAW = $clog2(MemD);
  localparam int CntD  = NUM_ROMS * 256;
  localparam int CAW   = $clog2(CntD);
  localparam int RIW   = (NUM_ROMS > 1) ? $clog2(NUM_ROMS) : 1;
  localparam int SW    = FPW + 1;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CLR    = 4'd1;
  localparam logic [3:0] S_CNT_RD = 4'd2;
  localparam logic [3:0] S_CNT_B  = 4'd3;
  localparam logic [3:0] S_CNT_WR = 4'd4;
  localparam logic [3:0] S_PRE_RD = 4'd5;
  localparam logic [3:0] S_PRE_WR = 4'd6;
  localparam logic [3:0] S_SC_RD  = 4'd7;
  localparam logic [3:0] S_SC_B   = 4'd8;
  localparam logic [3:0] S_SC_WR  = 4'd9;
  localparam logic [3:0] S_ELOOK  = 4'd10;
  localparam logic [3:0] S_EDIV   = 4'd11;
  localparam logic [3:0] S_ELIST  = 4'd12;

  logic [3:0]    state_q, state_d;
  cmd_t          cmd_q, cmd_cur;
  logic [FPW-1:0] fp_q [NUM_ROMS];
  logic [NUM_ROMS-1:0] built_q;
  logic [FPW-1:0] n_q, n_d, a_q, a_d, acc_q, acc_d;
  logic [7:0]    s_q, s_d, b_q, b_d;
  logic [AW-1:0] base_q, base_d;
  logic          out_valid_q, out_valid_d;
  out_t          out_q, out_d;

  logic [RIW-1:0]   ri;
  logic [MemAW-1:0] rom_base;
  logic [FPW-1:0]   fp_cur;
  logic             fp_set, fp_clr, built_set;
  logic [FPW-1:0]   fp_new;

  // memories
  logic [7:0]     rom_mem  [MemD];
  logic [AW-1:0]  list_mem [MemD];
  logic [FPW-1:0] cnt_mem  [CntD];
  logic [AW-1:0]  base_mem [CntD];
  logic [FPW-1:0] cur_mem  [256];
  logic [7:0]     rom_rd_q;
  logic [AW-1:0]  list_rd_q, base_rd_q;
  logic [FPW-1:0] cnt_rd_q, cur_rd_q;

  logic             rom_we, rom_re, list_we, list_re, cnt_we, cnt_re, base_we;
  logic             cur_we, cur_re;
  logic [MemAW-1:0] rom_wa, rom_ra, list_wa, list_ra;
  logic [7:0]       rom_wd;
  logic [AW-1:0]    list_wd, base_wd;
  logic [CAW-1:0]   cnt_wa, cnt_ra;
  logic [FPW-1:0]   cnt_wd, cur_wd;
  logic [7:0]       cur_wa, cur_ra;

  logic             div_start, div_done;
  logic [FPW-1:0]   div_rem;
  logic [SW-1:0]    slot;
  logic [AW-1:0]    slot_c;

  rahe_urem #(.VW(FPW)) u_urem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (cmd_q.random_value),
    .divisor_i  (cnt_rd_q),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  assign cmd_cur     = (state_q == S_IDLE) ? cmd_i : cmd_q;
  assign ri          = cmd_cur.rom[RIW-1:0];
  assign rom_base    = MemAW'(32'(cmd_cur.rom) * 32'(ROM_WINDOW));
  assign fp_cur      = fp_q[ri];
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign slot        = SW'(base_q) + SW'(div_rem);
  assign slot_c      = (slot >= SW'(ROM_WINDOW)) ? AW'(ROM_WINDOW - 1) : AW'(slot);

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    a_d         = a_q;
    acc_d       = acc_q;
    s_d         = s_q;
    b_d         = b_q;
    base_d      = base_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_d       = out_q;
    cmd_pop_o   = 1'b0;
    fp_set      = 1'b0;
    fp_clr      = 1'b0;
    fp_new      = fp_cur;
    built_set   = 1'b0;
    div_start   = 1'b0;
    rom_we  = 1'b0; rom_re  = 1'b0; list_we = 1'b0; list_re = 1'b0;
    cnt_we  = 1'b0; cnt_re  = 1'b0; base_we = 1'b0; cur_we  = 1'b0; cur_re = 1'b0;
    rom_wa  = rom_base + MemAW'(fp_cur);
    rom_wd  = cmd_cur.data_byte;
    rom_ra  = rom_base + MemAW'(a_q);
    list_wa = rom_base + MemAW'(cur_rd_q);
    list_wd = AW'(a_q);
    list_ra = rom_base + MemAW'(slot_c);
    cnt_wa  = CAW'({cmd_cur.rom, s_q});
    cnt_wd  = '0;
    cnt_ra  = CAW'({cmd_cur.rom, cmd_cur.data_byte});
    base_wd = AW'(acc_q);
    cur_wa  = s_q;
    cur_wd  = acc_q;
    cur_ra  = rom_rd_q;

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.op == OpLoad) begin
            n_d = fp_cur;
            if (fp_cur < FPW'(ROM_WINDOW)) begin
              rom_we = 1'b1;
              fp_set = 1'b1;
              fp_new = fp_cur + 1'b1;
              n_d    = fp_cur + 1'b1;
            end
            if (cmd_i.last_rom_byte) begin
              s_d     = 8'd0;
              state_d = S_CLR;
            end
          end else begin
            cnt_re  = 1'b1;
            state_d = S_ELOOK;
          end
        end
      end
      S_CLR: begin
        cnt_we = 1'b1;
        s_d    = s_q + 8'd1;
        if (s_q == 8'hFF) begin
          a_d     = '0;
          state_d = S_CNT_RD;
        end
      end
      S_CNT_RD: begin
        if (a_q == n_q) begin
          s_d     = 8'd0;
          acc_d   = '0;
          state_d = S_PRE_RD;
        end else begin
          rom_re  = 1'b1;
          state_d = S_CNT_B;
        end
      end
      S_CNT_B: begin
        cnt_re  = 1'b1;
        cnt_ra  = CAW'({cmd_q.rom, rom_rd_q});
        b_d     = rom_rd_q;
        state_d = S_CNT_WR;
      end
      S_CNT_WR: begin
        cnt_we  = 1'b1;
        cnt_wa  = CAW'({cmd_q.rom, b_q});
        cnt_wd  = cnt_rd_q + 1'b1;
        a_d     = a_q + 1'b1;
        state_d = S_CNT_RD;
      end
      S_PRE_RD: begin
        cnt_re  = 1'b1;
        cnt_ra  = CAW'({cmd_q.rom, s_q});
        state_d = S_PRE_WR;
      end
      S_PRE_WR: begin
        // bases are running sums of the counts; cursors start at the base
        base_we = 1'b1;
        cur_we  = 1'b1;
        acc_d   = acc_q + cnt_rd_q;
        s_d     = s_q + 8'd1;
        if (s_q == 8'hFF) begin
          a_d     = '0;
          state_d = S_SC_RD;
        end else begin
          state_d = S_PRE_RD;
        end
      end
      S_SC_RD: begin
        if (a_q == n_q) begin
          fp_clr    = 1'b1;
          built_set = 1'b1;
          state_d   = S_IDLE;
        end else begin
          rom_re  = 1'b1;
          state_d = S_SC_B;
        end
      end
      S_SC_B: begin
        cur_re  = 1'b1;
        b_d     = rom_rd_q;
        state_d = S_SC_WR;
      end
      S_SC_WR: begin
        list_we = (cur_rd_q < FPW'(ROM_WINDOW));
        cur_we  = 1'b1;
        cur_wa  = b_q;
        cur_wd  = cur_rd_q + 1'b1;
        a_d     = a_q + 1'b1;
        state_d = S_SC_RD;
      end
      S_ELOOK: begin
        if (!built_q[ri] || cnt_rd_q == '0) begin
          state_d = S_IDLE;
        end else begin
          div_start = 1'b1;
          base_d    = base_rd_q;
          state_d   = S_EDIV;
        end
      end
      S_EDIV: begin
        if (div_done) begin
          list_re = 1'b1;
          state_d = S_ELIST;
        end
      end
      S_ELIST: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d       = 1'b1;
          out_d.rom_address = 16'(list_rd_q);
          out_d.rom_used    = 2'(cmd_q.rom);
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      built_q     <= '0;
      for (int i = 0; i < NUM_ROMS; i++) begin
        fp_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (fp_set) begin
        fp_q[ri] <= fp_new;
      end else if (fp_clr) begin
        fp_q[ri] <= '0;
      end
      if (built_set) begin
        built_q[ri] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q <= cmd_i;
    end
    n_q    <= n_d;
    a_q    <= a_d;
    acc_q  <= acc_d;
    s_q    <= s_d;
    b_q    <= b_d;
    base_q <= base_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (rom_we) begin
      rom_mem[rom_wa] <= rom_wd;
    end
    if (rom_re) begin
      rom_rd_q <= rom_mem[rom_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (list_we) begin
      list_mem[list_wa] <= list_wd;
    end
    if (list_re) begin
      list_rd_q <= list_mem[list_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    if (cnt_re) begin
      cnt_rd_q <= cnt_mem[cnt_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (base_we) begin
      base_mem[cnt_wa] <= base_wd;
    end
    if (cnt_re) begin
      base_rd_q <= base_mem[cnt_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cur_we) begin
      cur_mem[cur_wa] <= cur_wd;
    end
    if (cur_re) begin
      cur_rd_q <= cur_mem[cur_ra];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/rom_address_homophonic_encoder.sv
// Homophonic encoder over key ROMs: top level joining front end and back end.
// Depends on rahe_pkg, rahe_front, rahe_back (and rahe_urem below it).
//
// Input channel (in_valid_i/in_ready_o, in_data_i): load items store ROM bytes,
// a load marked last builds that ROM's index; encode items yield zero or one
// result on the output channel (out_valid_o/out_ready_i, out_data_o).
// Config channel (cfg_valid_i/cfg_ready_o, cfg_data_i), always ready, writes
// rom_count; the user must write it only while the block is idle, unchecked.
// A two-entry command queue sits between front and back, so input transfers
// continue while the back works or a result waits for the receiver.
// A plain load is handled in the back's idle state. An encode result passes
// through the 32-bit remainder unit, one bit per cycle, and two memory reads in
// series (count and base, then list) before the output register.
// Index build: clear the 256 counts, count the n stored bytes, form bases and
// cursors, then scatter the n addresses into the list; the back takes no
// commands meanwhile and the input stalls once the queue holds two.
// Reset clears the queue, rotation, fill pointers and per-ROM built flags;
// rom_count returns to 1. An unbuilt ROM produces no result.
// When the receiver stalls, the result holds in the output register and the
// back stops at its next result until it is taken.
`default_nettype none

module rom_address_homophonic_encoder import rahe_pkg::*; #(
  parameter int ROM_WINDOW = DefWindow,
  parameter int NUM_ROMS   = DefNumRoms
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  in_t                 in_data_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output out_t                out_data_o,
  input  wire                 cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire [RomCountW-1:0] cfg_data_i
);

  logic cmd_valid, cmd_pop;
  cmd_t cmd;

  rahe_front #(.NUM_ROMS(NUM_ROMS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  rahe_back #(.ROM_WINDOW(ROM_WINDOW), .NUM_ROMS(NUM_ROMS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

FILE: tb/sv/rom_address_homophonic_encoder_tb.sv
// Testbench for rom_address_homophonic_encoder: loads key ROMs, encodes bytes
// and checks each emitted ROM address against an in-bench index predictor.
// Depends on rahe_pkg and the RTL of the block.
`default_nettype none

module rom_address_homophonic_encoder_tb;
  import rahe_pkg::*;

  localparam int Window  = DefWindow;
  localparam int NumRoms = DefNumRoms;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  in_t  in_data;
  logic in_ready;
  logic out_valid;
  logic out_ready;
  out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [RomCountW-1:0] cfg_data;

  always #4 clk = ~clk;

  rom_address_homophonic_encoder u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  // Predictor state: key ROM copies and their built indexes.
  logic [7:0]  key_rom   [NumRoms][Window];
  logic [15:0] addr_list [NumRoms][Window];
  logic [31:0] sym_count [NumRoms][256];
  logic [31:0] sym_base  [NumRoms][256];
  int          fill_ptr  [NumRoms];
  int          rot_pos;
  int          rom_count;

  out_t expected_addrs[$];
  int   mismatches;
  int   items_sent;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   hold_cycles;
  int   pending_build;   // largest index build since the last drain

  function automatic void build_index(int r);
    logic [31:0] cursor[256];
    logic [31:0] base;
    int n;
    n = fill_ptr[r];
    base = '0;
    for (int s = 0; s < 256; s++) sym_count[r][s] = '0;
    for (int a = 0; a < n; a++) sym_count[r][key_rom[r][a]]++;
    for (int s = 0; s < 256; s++) begin
      sym_base[r][s] = base & 32'hFFFF;
      cursor[s] = base;
      base += sym_count[r][s];
    end
    for (int a = 0; a < n; a++) begin
      if (cursor[key_rom[r][a]] < Window) addr_list[r][cursor[key_rom[r][a]]] = a[15:0];
      cursor[key_rom[r][a]]++;
    end
    fill_ptr[r] = 0;
    if (n > pending_build) pending_build = n;
  endfunction

  function automatic void predict_transfer(in_t it);
    int cnt, r;
    logic [31:0] slot;
    out_t res;
    if (it.op == OpLoad) begin
      rot_pos = 0;
      if (it.rom_select >= NumRoms) return;
      if (fill_ptr[it.rom_select] < Window) begin
        key_rom[it.rom_select][fill_ptr[it.rom_select]] = it.data_byte;
        fill_ptr[it.rom_select]++;
      end
      if (it.last_rom_byte) build_index(it.rom_select);
      return;
    end
    cnt = (rom_count == 0) ? 1 : (rom_count > NumRoms ? NumRoms : rom_count);
    r = rot_pos % cnt;
    rot_pos = (r + 1) % cnt;
    if (sym_count[r][it.data_byte] == 0) return;
    slot = sym_base[r][it.data_byte] + it.random_value % sym_count[r][it.data_byte];
    if (slot >= Window) slot = Window - 1;
    res.rom_address = addr_list[r][slot];
    res.rom_used = r[1:0];
    expected_addrs.push_back(res);
  endfunction

  // Receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_addrs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result addr=%0d rom=%0d", out_data.rom_address,
                   out_data.rom_used);
      end else begin
        if (out_data !== expected_addrs[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected addr=%0d rom=%0d, got addr=%0d rom=%0d",
                     expected_addrs[0].rom_address, expected_addrs[0].rom_used,
                     out_data.rom_address, out_data.rom_used);
        end
        void'(expected_addrs.pop_front());
      end
    end
  end

  // Valid stays up between back-to-back items; it drops only on idle or drain.
  task automatic send_item(in_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    predict_transfer(it);
    items_sent++;
  endtask

  task automatic load_byte(int r, logic [7:0] b, logic last);
    in_t it;
    it = '0;
    it.op = OpLoad;
    it.rom_select = r[1:0];
    it.data_byte = b;
    it.random_value = $urandom;
    it.last_rom_byte = last;
    send_item(it);
  endtask

  task automatic encode_byte(logic [7:0] b, logic [31:0] rnd);
    in_t it;
    it.op = OpEncode;
    it.rom_select = 2'($urandom_range(3));
    it.data_byte = b;
    it.random_value = rnd;
    it.last_rom_byte = 1'($urandom_range(1));
    send_item(it);
  endtask

  // Wait for all results, then for up to three index builds still in flight.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_addrs.size() != 0) @(posedge clk);
    repeat (3 * (800 + 6 * pending_build)) @(posedge clk);
    pending_build = 0;
  endtask

  task automatic write_rom_count(int v);
    cfg_valid <= 1'b1;
    cfg_data  <= v[RomCountW-1:0];
    do @(posedge clk); while (!cfg_ready);
    rom_count = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic load_rom(int r, int len, int alphabet);
    for (int i = 0; i < len; i++)
      load_byte(r, 8'($urandom_range(alphabet - 1)), i == len - 1);
  endtask

  task automatic test_directed();
    encode_byte(8'h00, 32'd0);          // nothing built yet
    load_byte(0, 8'h00, 1'b0);
    load_byte(0, 8'hFF, 1'b0);
    load_byte(0, 8'h00, 1'b0);
    load_byte(3, 8'h00, 1'b1);          // rom_select beyond the ROMs is dropped
    load_byte(0, 8'h5A, 1'b1);
    encode_byte(8'h00, 32'd0);
    encode_byte(8'h00, 32'hFFFF_FFFF);
    encode_byte(8'hFF, 32'hFFFF_FFFF);
    encode_byte(8'h5A, 32'h8000_0001);
    encode_byte(8'h07, $urandom);       // absent byte
    load_byte(1, 8'hA5, 1'b1);
    drain();
    write_rom_count(3);
    for (int i = 0; i < 6; i++) encode_byte(i[0] ? 8'hA5 : 8'h00, $urandom);
    drain();
  endtask

  task automatic test_config_sweep();
    int vals[4] = '{0, 2, 3, 1};
    load_rom(2, 20, 4);
    load_rom(1, 20, 4);
    drain();
    foreach (vals[k]) begin
      write_rom_count(vals[k]);
      for (int i = 0; i < 12; i++) encode_byte(8'($urandom_range(3)), $urandom);
      drain();
    end
  endtask

  task automatic random_phase(int n, int s_idle, int r_idle, int rc, bit pressure);
    int sel;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    write_rom_count(rc);
    for (int r = 0; r < NumRoms; r++) load_rom(r, $urandom_range(1, 40), 16);
    for (int i = 0; i < n; i++) begin
      if (pressure && i == n / 2) hold_cycles = 400;
      sel = $urandom_range(99);
      if (sel < 80)
        encode_byte(8'(($urandom_range(9) == 0) ? $urandom : $urandom_range(15)),
                    $urandom);
      else if (sel < 88)
        load_rom($urandom_range(NumRoms - 1), $urandom_range(1, 24),
                 ($urandom_range(3) == 0) ? 256 : 16);
      else
        load_byte($urandom_range(3), 8'($urandom), 1'($urandom_range(1)));
    end
    drain();
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    out_ready <= 1'b0;
    hold_cycles = 0;
    mismatches = 0;
    items_sent = 0;
    send_idle_pct = 9;
    recv_idle_pct = 61;
    pending_build = 0;
    rot_pos = 0;
    rom_count = 1;
    for (int r = 0; r < NumRoms; r++) begin
      fill_ptr[r] = 0;
      for (int s = 0; s < 256; s++) begin
        sym_count[r][s] = '0;
        sym_base[r][s] = '0;
      end
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_config_sweep();
    random_phase(220, 9, 61, 2, 1'b0);
    random_phase(220, 61, 9, 3, 1'b1);
    random_phase(220, 0, 0, 1, 1'b1);
    if (mismatches == 0 && expected_addrs.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #80_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/core/rahe_pkg.sv
rtl/core/rahe_front.sv
rtl/core/rahe_urem.sv
rtl/core/rahe_back.sv
rtl/core/rom_address_homophonic_encoder.sv
tb/sv/rom_address_homophonic_encoder_tb.sv
